// ----- sv/assert_macros.svh -----
// Assertion macros used by the timer pool controller (tpc_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define TPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define TPC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPC_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- sv/tpc_pkg.sv -----
// Types, codes and sizes shared by the timer pool modules.
package tpc_pkg;

    localparam int NUM_TIMERS = 16;
    // Indexes are four bits wide, so at most sixteen timers exist.
    localparam int POOL_SIZE = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    localparam logic [2:0] KIND_ALLOC = 3'd0;
    localparam logic [2:0] KIND_BIND  = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_FREE  = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;

    localparam logic RES_ALLOC  = 1'b0;
    localparam logic RES_EXPIRY = 1'b1;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_RUN   = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  timer_index;
        logic [31:0] timeout;
        logic [3:0]  fifo_channel;
        logic [7:0]  event_data;
    } cmd_t;

    typedef struct packed {
        logic        result_kind;
        logic        alloc_ok;
        logic [3:0]  slot;
        logic [3:0]  target_channel;
        logic [7:0]  payload;
        logic [31:0] tick_total;
        logic        last;
    } res_t;

    // One write into the timer file per cycle.
    typedef struct packed {
        logic             status_en;
        status_t          status;
        logic             count_en;
        logic [31:0]      count;
        logic             bind_en;
        logic [3:0]       chan;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } wr_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] count;
        logic [3:0]  chan;
        logic [7:0]  data;
    } rd_t;

endpackage

// ----- sv/tpc_dec_unit.sv -----
// Shared decrement and zero-detect unit used by the tick scan.
module tpc_dec_unit (
    input  logic [31:0] value,
    output logic [31:0] value_dec,
    output logic        is_zero
);

    assign value_dec = value - 32'd1;
    assign is_zero   = (value_dec == 32'd0);

endmodule

// ----- sv/tpc_file.sv -----
// Per-timer state: status, remaining count, bound channel and data byte.
module tpc_file (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tpc_pkg::wr_t              wr,
    input  logic [tpc_pkg::IDX_W-1:0] rd_idx,
    output tpc_pkg::rd_t              rd
);

    tpc_pkg::status_t status_reg [tpc_pkg::POOL_SIZE];
    logic [31:0]      count_reg  [tpc_pkg::POOL_SIZE];
    logic [3:0]       chan_reg   [tpc_pkg::POOL_SIZE];
    logic [7:0]       data_reg   [tpc_pkg::POOL_SIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpc_pkg::POOL_SIZE; i++)
            begin
                status_reg[i] <= tpc_pkg::ST_FREE;
                count_reg[i]  <= 32'd0;
                chan_reg[i]   <= 4'd0;
                data_reg[i]   <= 8'd0;
            end
        end
        else
        begin
            if (wr.status_en)
                status_reg[wr.idx] <= wr.status;
            if (wr.count_en)
                count_reg[wr.idx] <= wr.count;
            if (wr.bind_en)
            begin
                chan_reg[wr.idx] <= wr.chan;
                data_reg[wr.idx] <= wr.data;
            end
        end
    end

    assign rd.status = status_reg[rd_idx];
    assign rd.count  = count_reg[rd_idx];
    assign rd.chan   = chan_reg[rd_idx];
    assign rd.data   = data_reg[rd_idx];

endmodule

// ----- sv/tpc_ctrl.sv -----
// Command sequencer: decodes items, scans the timers and stages results.
`include "assert_macros.svh"

module tpc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  tpc_pkg::cmd_t             cmd,
    output logic                      res_valid,
    input  logic                      res_ready,
    output tpc_pkg::res_t             res,
    output tpc_pkg::wr_t              wr,
    output logic [tpc_pkg::IDX_W-1:0] rd_idx,
    input  tpc_pkg::rd_t              rd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALLOC = 3'b010,
        S_TICK  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [tpc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [31:0]               tick_reg, tick_next;
    logic                      stage_valid_reg, stage_valid_next;
    tpc_pkg::res_t             stage_reg, stage_next;
    logic                      out_valid_reg;
    tpc_pkg::res_t             out_reg;

    logic          load_out;
    tpc_pkg::res_t out_new;
    logic          scan_end;
    logic          out_free;
    logic          in_range;
    logic [31:0]   count_dec;
    logic          count_zero;

    tpc_dec_unit u_dec (
        .value     (rd.count),
        .value_dec (count_dec),
        .is_zero   (count_zero)
    );

    assign rd_idx    = idx_reg[tpc_pkg::IDX_W-1:0];
    assign scan_end  = (idx_reg == tpc_pkg::CNT_W'(tpc_pkg::POOL_SIZE));
    assign out_free  = !out_valid_reg || res_ready;
    assign in_range  = (int'(cmd.timer_index) < tpc_pkg::POOL_SIZE);
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        tick_next        = tick_reg;
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        load_out         = 1'b0;
        out_new          = '0;
        wr               = '0;
        wr.idx           = rd_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    wr.idx   = cmd.timer_index[tpc_pkg::IDX_W-1:0];
                    wr.count = cmd.timeout;
                    wr.chan  = cmd.fifo_channel;
                    wr.data  = cmd.event_data;
                    case (cmd.kind)
                        tpc_pkg::KIND_ALLOC:
                        begin
                            idx_next   = '0;
                            state_next = S_ALLOC;
                        end
                        tpc_pkg::KIND_BIND:
                            wr.bind_en = in_range;
                        tpc_pkg::KIND_START:
                        begin
                            wr.count_en  = in_range;
                            wr.status_en = in_range;
                            wr.status    = tpc_pkg::ST_RUN;
                        end
                        tpc_pkg::KIND_FREE:
                        begin
                            wr.status_en = in_range;
                            wr.status    = tpc_pkg::ST_FREE;
                        end
                        tpc_pkg::KIND_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            idx_next   = '0;
                            state_next = S_TICK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (scan_end)
                begin
                    // No free timer: reply with a failure.
                    if (out_free)
                    begin
                        load_out             = 1'b1;
                        out_new.result_kind  = tpc_pkg::RES_ALLOC;
                        out_new.last         = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else if (rd.status == tpc_pkg::ST_FREE)
                begin
                    if (out_free)
                    begin
                        wr.status_en         = 1'b1;
                        wr.status            = tpc_pkg::ST_ALLOC;
                        load_out             = 1'b1;
                        out_new.result_kind  = tpc_pkg::RES_ALLOC;
                        out_new.alloc_ok     = 1'b1;
                        out_new.slot         = 4'(rd_idx);
                        out_new.last         = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TICK:
            begin
                if (scan_end)
                begin
                    // The staged expiry is the final one of this tick.
                    if (!stage_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        load_out         = 1'b1;
                        out_new          = stage_reg;
                        out_new.last     = 1'b1;
                        stage_valid_next = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
                else if (rd.status == tpc_pkg::ST_RUN && count_zero)
                begin
                    // An earlier expiry is held back until we know it is not the last.
                    if (!stage_valid_reg || out_free)
                    begin
                        wr.count_en               = 1'b1;
                        wr.count                  = count_dec;
                        wr.status_en              = 1'b1;
                        wr.status                 = tpc_pkg::ST_ALLOC;
                        load_out                  = stage_valid_reg;
                        out_new                   = stage_reg;
                        stage_valid_next          = 1'b1;
                        stage_next                = '0;
                        stage_next.result_kind    = tpc_pkg::RES_EXPIRY;
                        stage_next.slot           = 4'(rd_idx);
                        stage_next.target_channel = rd.chan;
                        stage_next.payload        = rd.data;
                        stage_next.tick_total     = tick_reg;
                        idx_next                  = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rd.status == tpc_pkg::ST_RUN)
                    begin
                        wr.count_en = 1'b1;
                        wr.count    = count_dec;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            tick_reg        <= 32'd0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            tick_reg        <= tick_next;
            stage_valid_reg <= stage_valid_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        if (load_out)
            out_reg <= out_new;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `TPC_ASSERT(a_stage_only_in_tick, clk, rst_n, stage_valid_reg |-> state_reg == S_TICK, "staged expiry outside tick scan")
    `TPC_ASSERT(a_idx_bound, clk, rst_n, idx_reg <= tpc_pkg::CNT_W'(tpc_pkg::POOL_SIZE), "scan index past pool")
    `TPC_ASSERT(a_not_last_keeps_stage, clk, rst_n, (load_out && !out_new.last) |=> stage_valid_reg, "non-final expiry sent with nothing staged")
    `TPC_NEVER(a_load_while_busy, clk, rst_n, load_out && out_valid_reg && !res_ready, "result overwritten before taken")

endmodule

// ----- sv/timer_pool_countdown.sv -----
// Top level of the countdown timer pool.
//
// A pool of up to sixteen countdown timers (tpc_pkg::NUM_TIMERS) driven by command items:
// alloc, bind, start, free and tick. Bind, start and free are done in the cycle they are
// taken and ready stays high. An alloc scans from timer 0 one timer per cycle up to the
// lowest free index, or through the whole pool when every timer is in use, and its reply
// waits for the output register to empty. A tick visits every timer once through the
// shared decrement and zero-detect unit, one timer per cycle except while an expiry waits
// for the output register to empty. Expiry results leave in index order, the final one of
// a tick marked by last; each alloc gives exactly one result with last set. One output
// register separates the result port, so a bind, start or free may be taken while a
// result waits there.
module timer_pool_countdown (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tpc_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output tpc_pkg::res_t res
);

    tpc_pkg::wr_t              wr;
    tpc_pkg::rd_t              rd;
    logic [tpc_pkg::IDX_W-1:0] rd_idx;

    tpc_file u_file (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd     (rd)
    );

    tpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr        (wr),
        .rd_idx    (rd_idx),
        .rd        (rd)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the countdown timer pool: random and directed command items.
module testbench;
    import tpc_pkg::*;

    // A kind code that the block does not decode and must ignore.
    localparam logic [2:0] KIND_SPARE = 3'd7;

    localparam int PLAN_ITEMS  = 330;
    localparam int IDLE_PCT    = 12;
    localparam int STALL_AT    = 120;
    localparam int STALL_LEN   = 300;
    localparam int QUIET_LO    = 180;
    localparam int QUIET_HI    = 260;
    localparam int DRAIN_TAIL  = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        cmd_t c;
        bit   pause;
    } plan_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    plan_t pending[$];
    res_t  expected_results[$];

    // Timer pool as the predictor sees it.
    status_t     timer_status[POOL_SIZE];
    logic [31:0] timer_left[POOL_SIZE];
    logic [3:0]  timer_chan[POOL_SIZE];
    logic [7:0]  timer_byte[POOL_SIZE];
    logic [31:0] model_ticks;

    int planned = 0;
    int cmds_taken = 0;
    int results_due = 0;
    int results_seen = 0;
    int errors = 0;
    int expiries = 0;
    int refused_allocs = 0;
    int peak_burst = 0;
    int produced_now;
    int cycle_count = 0;
    int stall_left;
    bit stall_done;
    logic send_took;
    logic quiet;
    res_t want;

    timer_pool_countdown uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #6 clk = ~clk;

    task automatic add_cmd(input logic [2:0] kind, input logic [3:0] idx,
                           input logic [31:0] tmo, input logic [3:0] ch,
                           input logic [7:0] data);
        plan_t p;
        p.c.kind = kind;
        p.c.timer_index = idx;
        p.c.timeout = tmo;
        p.c.fifo_channel = ch;
        p.c.event_data = data;
        p.pause = 1'b0;
        pending.push_back(p);
        if (kind <= KIND_TICK)
            planned++;
    endtask

    // Queues an item of the given kind with every other field random.
    task automatic add_random(input logic [2:0] kind);
        add_cmd(kind, 4'($urandom), $urandom, 4'($urandom), 8'($urandom));
    endtask

    task automatic add_pause();
        plan_t p;
        p.c = '0;
        p.pause = 1'b1;
        pending.push_back(p);
    endtask

    // Mostly short timeouts so that timers expire often, with some full-range ones.
    function automatic logic [31:0] pick_timeout();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(1, 6);
        else if (roll < 85)
            return $urandom_range(7, 40);
        else if (roll < 95)
            return $urandom;
        else
            return '0;
    endfunction

    // Applies one accepted command to the predicted pool and queues the results it causes.
    task automatic apply_command(input cmd_t c, output int produced);
        res_t r;
        int i;
        produced = 0;
        case (c.kind)
            KIND_ALLOC:
            begin
                r = '0;
                r.result_kind = RES_ALLOC;
                r.last = 1'b1;
                for (i = 0; i < POOL_SIZE; i++)
                begin
                    if (timer_status[i] == ST_FREE && !r.alloc_ok)
                    begin
                        timer_status[i] = ST_ALLOC;
                        r.alloc_ok = 1'b1;
                        r.slot = 4'(i);
                    end
                end
                if (!r.alloc_ok)
                    refused_allocs++;
                expected_results.push_back(r);
                produced = 1;
            end
            KIND_BIND:
            begin
                if (c.timer_index < POOL_SIZE)
                begin
                    timer_chan[c.timer_index] = c.fifo_channel;
                    timer_byte[c.timer_index] = c.event_data;
                end
            end
            KIND_START:
            begin
                if (c.timer_index < POOL_SIZE)
                begin
                    timer_left[c.timer_index] = c.timeout;
                    timer_status[c.timer_index] = ST_RUN;
                end
            end
            KIND_FREE:
            begin
                if (c.timer_index < POOL_SIZE)
                    timer_status[c.timer_index] = ST_FREE;
            end
            KIND_TICK:
            begin
                model_ticks = model_ticks + 32'd1;
                for (i = 0; i < POOL_SIZE; i++)
                begin
                    if (timer_status[i] == ST_RUN)
                    begin
                        timer_left[i] = timer_left[i] - 32'd1;
                        if (timer_left[i] == 32'd0)
                        begin
                            timer_status[i] = ST_ALLOC;
                            r = '0;
                            r.result_kind = RES_EXPIRY;
                            r.slot = 4'(i);
                            r.target_channel = timer_chan[i];
                            r.payload = timer_byte[i];
                            r.tick_total = model_ticks;
                            expected_results.push_back(r);
                            produced++;
                        end
                    end
                end
                // Only the final expiry of a tick carries the last flag.
                if (produced > 0)
                begin
                    r = expected_results.pop_back();
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                expiries += produced;
                if (produced > peak_burst)
                    peak_burst = produced;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, exp_val, got_val);
    endtask

    // Sender: presents planned items, holds each until taken, and waits out pause markers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            send_took = cmd_valid && cmd_ready;
            quiet = cmds_taken >= QUIET_LO && cmds_taken < QUIET_HI;
            if (send_took || !cmd_valid)
            begin
                if (pending.size() == 0)
                    cmd_valid <= 1'b0;
                else if (pending[0].pause)
                begin
                    if (!send_took && results_seen == results_due)
                        pending.delete(0);
                    cmd_valid <= 1'b0;
                end
                else if (quiet || $urandom_range(99) >= IDLE_PCT)
                begin
                    cmd <= pending[0].c;
                    cmd_valid <= 1'b1;
                    pending.delete(0);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch that never stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end
        else if (!stall_done && cmds_taken >= STALL_AT)
        begin
            stall_done = 1'b1;
            stall_left = STALL_LEN;
            res_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            res_ready <= 1'b0;
        end
        else if (cmds_taken >= QUIET_LO && cmds_taken < QUIET_HI)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: checks each result, then feeds the command taken at this edge to the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                timer_status[i] = ST_FREE;
                timer_left[i] = '0;
                timer_chan[i] = '0;
                timer_byte[i] = '0;
            end
            model_ticks = '0;
            expected_results.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, got kind %0d slot %0d",
                             $time, res.result_kind, res.slot);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.result_kind !== want.result_kind)
                        flag_field("result_kind", 32'(want.result_kind),
                                   32'(res.result_kind));
                    if (res.alloc_ok !== want.alloc_ok)
                        flag_field("alloc_ok", 32'(want.alloc_ok), 32'(res.alloc_ok));
                    if (res.slot !== want.slot)
                        flag_field("slot", 32'(want.slot), 32'(res.slot));
                    if (res.target_channel !== want.target_channel)
                        flag_field("target_channel", 32'(want.target_channel),
                                   32'(res.target_channel));
                    if (res.payload !== want.payload)
                        flag_field("payload", 32'(want.payload), 32'(res.payload));
                    if (res.tick_total !== want.tick_total)
                        flag_field("tick_total", want.tick_total, res.tick_total);
                    if (res.last !== want.last)
                        flag_field("last", 32'(want.last), 32'(res.last));
                    results_seen <= results_seen + 1;
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                apply_command(cmd, produced_now);
                results_due <= results_due + produced_now;
                cmds_taken <= cmds_taken + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, expected_results.size());
            $display("timer_pool_countdown verification failed");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int span;
        int k;
        logic [3:0] slot_pick;
        logic [31:0] tmo_pick;
        bit mid_pause;

        mid_pause = 1'b0;

        // Directed opening: both index extremes, every command, a start on a free timer,
        // a zero timeout, the largest timeout, a free while running and an ignored kind.
        add_cmd(KIND_ALLOC, '0, '0, '0, '0);
        add_cmd(KIND_ALLOC, '0, '0, '0, '0);
        add_cmd(KIND_BIND, 4'd0, '0, 4'd15, 8'd255);
        add_cmd(KIND_BIND, 4'd15, '0, 4'd0, 8'd0);
        add_cmd(KIND_BIND, 4'd3, '0, 4'd5, 8'ha5);
        add_cmd(KIND_START, 4'd0, 32'd1, '0, '0);
        add_cmd(KIND_START, 4'd15, 32'd1, '0, '0);
        add_cmd(KIND_START, 4'd3, 32'd0, '0, '0);
        add_cmd(KIND_START, 4'd4, 32'hffff_ffff, '0, '0);
        add_cmd(KIND_FREE, 4'd4, '0, '0, '0);
        add_cmd(KIND_TICK, '0, '0, '0, '0);
        add_cmd(KIND_TICK, '0, '0, '0, '0);
        add_cmd(KIND_SPARE, 4'd15, 32'hffff_ffff, 4'd15, 8'd255);
        add_cmd(KIND_FREE, 4'd0, '0, '0, '0);
        add_cmd(KIND_ALLOC, '0, '0, '0, '0);
        add_cmd(KIND_FREE, 4'd3, '0, '0, '0);
        add_cmd(KIND_START, 4'd3, 32'd2, '0, '0);
        add_cmd(KIND_TICK, '0, '0, '0, '0);
        add_cmd(KIND_TICK, '0, '0, '0, '0);
        add_pause();

        while (planned < PLAN_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                // Typical use: claim, bind, start, then let time pass.
                slot_pick = 4'($urandom_range(15));
                add_random(KIND_ALLOC);
                add_cmd(KIND_BIND, slot_pick, $urandom, 4'($urandom), 8'($urandom));
                add_cmd(KIND_START, slot_pick, pick_timeout(), 4'($urandom), 8'($urandom));
                repeat ($urandom_range(3))
                    add_random(KIND_TICK);
            end
            else if (pick < 62)
            begin
                repeat ($urandom_range(1, 6))
                    add_random(KIND_TICK);
            end
            else if (pick < 72)
                add_random(KIND_FREE);
            else if (pick < 76)
            begin
                // Exhaust the pool so that at least one alloc is refused, then reopen some.
                repeat (POOL_SIZE + 1)
                    add_random(KIND_ALLOC);
                repeat ($urandom_range(3, 8))
                    add_random(KIND_FREE);
            end
            else if (pick < 82)
            begin
                // Many timers due on the same tick, often the whole pool.
                span = $urandom_range(1) ? POOL_SIZE : $urandom_range(2, POOL_SIZE - 1);
                tmo_pick = $urandom_range(1, 3);
                for (k = 0; k < span; k++)
                    add_cmd(KIND_START, 4'(k), tmo_pick, 4'($urandom), 8'($urandom));
                repeat (tmo_pick)
                    add_random(KIND_TICK);
            end
            else
                add_random(3'($urandom_range(7)));
            if (!mid_pause && planned >= 200)
            begin
                add_pause();
                mid_pause = 1'b1;
            end
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || cmd_valid || results_seen != results_due)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("Ran %0d commands and checked %0d results, %0d of them expiries.",
                 cmds_taken, results_seen, expiries);
        $display("Largest expiry burst on one tick: %0d; allocs refused on a full pool: %0d.",
                 peak_burst, refused_allocs);
        if (errors == 0)
            $display("timer_pool_countdown verification clean");
        else
            $display("timer_pool_countdown verification failed");
        $finish;
    end

endmodule
